>>> sv/fla_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_pkg: shared types and constants
// Field widths, status and mode codes, register indexes and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package fla_pkg;

  // field widths
  localparam int IDX_FIELD_W = 10;
  localparam int CNT_W       = 11;
  localparam int ADDR_W      = 48;
  localparam int STRIDE_W    = 21;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;

  // register reset values
  localparam logic [CNT_W-1:0]    BC_RESET     = 11'd1024;
  localparam logic [ADDR_W-1:0]   BASE_RESET   = 48'd0;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 21'd4096;

  // register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BLOCK_COUNT  = 2'd0;
  localparam cfg_idx_t CFG_BASE_ADDRESS = 2'd1;
  localparam cfg_idx_t CFG_BLOCK_STRIDE = 2'd2;

  // result status codes
  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  // operation codes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic take;   // capture the incoming word
    logic exec;   // decide, update list, issue link read
    logic load;   // fill the output register
    logic sweep;  // write one link of the initial chain
  } fla_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reinit;      // block_count written this cycle
    logic sweep_last;  // last link of the chain being written
  } fla_sts_t;

endpackage
`default_nettype wire

>>> sv/fla_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_in_if: request channel
// Valid/ready channel carrying one allocate or free request word.
// ----------------------------------------------------------------------------
interface fla_in_if
  import fla_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [IDX_FIELD_W-1:0] free_index;

  modport source (output valid, output mode, output free_index, input ready);
  modport sink   (input valid, input mode, input free_index, output ready);
endinterface
`default_nettype wire

>>> sv/fla_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_out_if: result channel
// Valid/ready channel carrying one result word per request.
// ----------------------------------------------------------------------------
interface fla_out_if
  import fla_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [IDX_FIELD_W-1:0] block_index;
  logic [ADDR_W-1:0]      block_address;
  logic [CNT_W-1:0]       free_count;
  logic [CNT_W-1:0]       used_count;
  logic [CNT_W-1:0]       total_blocks;

  modport source (output valid, output status, output block_index, output block_address,
                  output free_count, output used_count, output total_blocks, input ready);
  modport sink   (input valid, input status, input block_index, input block_address,
                  input free_count, input used_count, input total_blocks, output ready);
endinterface
`default_nettype wire

>>> sv/free_list_block_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// free_list_block_allocator: LIFO free-list block allocator
// Pool of equal blocks kept as a linked stack of free indices; allocate pops
// the head and returns index and bus address, free pushes an index back.
//
//   channel   dir  handshake         word
//   in_chan   in   valid/ready       mode, free_index
//   out_chan  out  valid/ready       status, block_index, block_address,
//                                    free_count, used_count, total_blocks
//   cfg_*     in   write enable      cfg_index, cfg_data
//
// Each request passes an execute step, which decides and reads the link of
// the head, then a finish step, which loads the result. A new word is taken
// in the cycle its predecessor's result loads, so words never overlap in
// execution, a limit set by the registered read of the link memory.
// After reset and after each block_count write a sweep writes the initial
// chain of MAX_BLOCKS links; no word is taken meanwhile.
// A stalled result waits in the output register; one more word may complete
// behind it and then holds until the register frees.
// ----------------------------------------------------------------------------
module free_list_block_allocator
  import fla_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fla_in_if.sink                     in_chan,
  fla_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  fla_cmd_t cmd;
  fla_sts_t sts;

  // sequencing
  fla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // list state and result
  fla_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_mode           (in_chan.mode),
    .in_free_index     (in_chan.free_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_status        (out_chan.status),
    .out_block_index   (out_chan.block_index),
    .out_block_address (out_chan.block_address),
    .out_free_count    (out_chan.free_count),
    .out_used_count    (out_chan.used_count),
    .out_total_blocks  (out_chan.total_blocks)
  );

endmodule
`default_nettype wire

>>> sv/fla_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_ctrl: allocator controller
// Sequences link sweep, request execution and result hand-off, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module fla_ctrl
  import fla_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire fla_sts_t sts,
  output fla_cmd_t      cmd
);

  typedef enum logic [1:0] {S_SWEEP, S_IDLE, S_EXEC, S_FIN} state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   slot_free;
  logic   accept;

  // handshake and command decode; no word taken while the pool is rebuilt
  always_comb begin
    slot_free = !out_valid_r || out_ready;
    in_ready  = !sts.reinit &&
                ((state_r == S_IDLE) || ((state_r == S_FIN) && slot_free));
    accept    = in_valid && in_ready;
    cmd.take  = accept;
    cmd.exec  = (state_r == S_EXEC);
    cmd.load  = (state_r == S_FIN) && slot_free;
    cmd.sweep = (state_r == S_SWEEP);
  end

  assign out_valid = out_valid_r;

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (sts.reinit) begin
        state_r <= S_SWEEP;
      end else begin
        unique case (state_r)
          S_SWEEP: begin
            if (sts.sweep_last) state_r <= S_IDLE;
          end
          S_IDLE: begin
            if (accept) state_r <= S_EXEC;
          end
          S_EXEC: begin
            state_r <= S_FIN;
          end
          S_FIN: begin
            if (slot_free) state_r <= accept ? S_EXEC : S_IDLE;
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  // a result only lands in a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending word");

  // no request taken while the link chain is being written
  a_sweep_block: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SWEEP) |-> !in_ready)
    else $error("request accepted during link sweep");

  // output valid rises only from a load
  a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load))
    else $error("output valid without a load");

endmodule
`default_nettype wire

>>> sv/fla_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fla_dp: allocator datapath
// Configuration registers, list head, free count, link memory, address
// multiplier and the output register.
// ----------------------------------------------------------------------------
module fla_dp
  import fla_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fla_cmd_t               cmd,
  output fla_sts_t                    sts,
  input  wire logic                   in_mode,
  input  wire logic [IDX_FIELD_W-1:0] in_free_index,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output logic [STATUS_W-1:0]         out_status,
  output logic [IDX_FIELD_W-1:0]      out_block_index,
  output logic [ADDR_W-1:0]           out_block_address,
  output logic [CNT_W-1:0]            out_free_count,
  output logic [CNT_W-1:0]            out_used_count,
  output logic [CNT_W-1:0]            out_total_blocks
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int XW     = (IDX_W > IDX_FIELD_W) ? IDX_W : IDX_FIELD_W;
  localparam int PROD_W = STRIDE_W + IDX_W;

  // pool size from a block_count value
  function automatic logic [CNT_W-1:0] pool_clamp(input logic [CNT_W-1:0] bc);
    logic [CNT_W-1:0] n;
    if (bc == '0) begin
      n = CNT_W'(1);
    end else if (int'(bc) > MAX_BLOCKS) begin
      n = CNT_W'(MAX_BLOCKS);
    end else begin
      n = bc;
    end
    return n;
  endfunction

  // control state
  logic [ADDR_W-1:0]   base_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [CNT_W-1:0]    pool_r;
  logic [IDX_W-1:0]    head_r;
  logic [CNT_W-1:0]    free_total_r;
  logic [IDX_W-1:0]    sweep_cnt_r;

  // request and working registers
  logic                   op_mode_r;
  logic [IDX_FIELD_W-1:0] op_idx_r;
  logic                   alloc_ok_r;
  status_t                status_r;
  logic [PROD_W-1:0]      prod_r;
  logic [IDX_W-1:0]       sel_idx_r;

  // link memory
  logic [IDX_W-1:0] link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0] link_rd_r;

  // output register
  logic [STATUS_W-1:0]    out_status_r;
  logic [IDX_FIELD_W-1:0] out_block_index_r;
  logic [ADDR_W-1:0]      out_block_address_r;
  logic [CNT_W-1:0]       out_free_count_r;
  logic [CNT_W-1:0]       out_used_count_r;
  logic [CNT_W-1:0]       out_total_blocks_r;

  logic             reinit;
  logic             alloc_ok;
  logic             free_ok;
  status_t          status_nxt;
  logic [XW-1:0]    fi_wide;
  logic [XW-1:0]    sel_wide;
  logic [IDX_W-1:0] free_addr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_wdata;

  // decisions on the captured request
  always_comb begin
    reinit     = cfg_we && (cfg_index == CFG_BLOCK_COUNT);
    fi_wide    = XW'(op_idx_r);
    free_addr  = fi_wide[IDX_W-1:0];
    sel_wide   = XW'(sel_idx_r);
    alloc_ok   = (op_mode_r == MODE_ALLOC) && (free_total_r != '0);
    free_ok    = (op_mode_r == MODE_FREE) && ({1'b0, op_idx_r} < pool_r) &&
                 (free_total_r < pool_r);
    if (op_mode_r == MODE_ALLOC) begin
      status_nxt = alloc_ok ? ST_OK : ST_EMPTY;
    end else begin
      status_nxt = free_ok ? ST_OK : ST_RANGE;
    end
    mem_we    = cmd.sweep || (cmd.exec && free_ok);
    mem_waddr = cmd.sweep ? sweep_cnt_r : free_addr;
    mem_wdata = cmd.sweep ? IDX_W'(sweep_cnt_r + 1'b1) : head_r;
    sts.reinit     = reinit;
    sts.sweep_last = (sweep_cnt_r == IDX_W'(MAX_BLOCKS - 1));
  end

  // configuration, list head and free count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r        <= BASE_RESET;
      stride_r      <= STRIDE_RESET;
      pool_r        <= pool_clamp(BC_RESET);
      head_r        <= '0;
      free_total_r  <= pool_clamp(BC_RESET);
      sweep_cnt_r   <= '0;
    end else begin
      if (cfg_we && (cfg_index == CFG_BASE_ADDRESS)) base_r <= cfg_data[ADDR_W-1:0];
      if (cfg_we && (cfg_index == CFG_BLOCK_STRIDE)) stride_r <= cfg_data[STRIDE_W-1:0];
      if (reinit) begin
        pool_r        <= pool_clamp(cfg_data[CNT_W-1:0]);
        free_total_r  <= pool_clamp(cfg_data[CNT_W-1:0]);
        head_r        <= '0;
        sweep_cnt_r   <= '0;
      end else begin
        if (cmd.sweep) sweep_cnt_r <= sweep_cnt_r + 1'b1;
        if (cmd.exec && free_ok) begin
          head_r       <= free_addr;
          free_total_r <= free_total_r + 1'b1;
        end
        if (cmd.exec && alloc_ok) free_total_r <= free_total_r - 1'b1;
        if (cmd.load && alloc_ok_r) head_r <= link_rd_r;
      end
    end
  end

  // link memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (cmd.exec) link_rd_r <= link_mem[head_r];
  end

  // request capture, address product and output register
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_mode_r <= in_mode;
      op_idx_r  <= in_free_index;
    end
    if (cmd.exec) begin
      alloc_ok_r <= alloc_ok;
      status_r   <= status_nxt;
      prod_r     <= PROD_W'(stride_r) * PROD_W'(head_r);
      sel_idx_r  <= head_r;
    end
    if (cmd.load) begin
      out_status_r        <= status_r;
      out_block_index_r   <= alloc_ok_r ? sel_wide[IDX_FIELD_W-1:0] : '0;
      out_block_address_r <= alloc_ok_r ? (base_r + ADDR_W'(prod_r)) : '0;
      out_free_count_r    <= free_total_r;
      out_used_count_r    <= pool_r - free_total_r;
      out_total_blocks_r  <= pool_r;
    end
  end

  assign out_status        = out_status_r;
  assign out_block_index   = out_block_index_r;
  assign out_block_address = out_block_address_r;
  assign out_free_count    = out_free_count_r;
  assign out_used_count    = out_used_count_r;
  assign out_total_blocks  = out_total_blocks_r;

endmodule
`default_nettype wire
